// File: sv/rcpi_pkg.sv
// Shared types and constants for the refined cell parent index block.
// No dependencies; imported by every module of the block but rcpi_ram.
package rcpi_pkg;

   // Field widths fixed by the word format
   localparam int CoordBits       = 16;
   localparam int OffsetBits      = 32;
   localparam int BoxNumBits      = 6;
   localparam int MaxBoxesDefault = 64;

   // Command codes carried in the request word
   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   // Status codes returned in the response word
   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   // Fixed responses that need no datapath work
   typedef enum logic [1:0] {
      RES_NONE = 2'd0,
      RES_OK   = 2'd1,
      RES_MISS = 2'd2,
      RES_FULL = 2'd3
   } res_kind_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_APP_SPAN,
      ST_APP_MUL,
      ST_APP_ACC,
      ST_QRY_FIRST,
      ST_QRY_SCAN,
      ST_QRY_MUL,
      ST_QRY_SUM,
      ST_RESP
   } state_type;

   // One stored box: corners and starting flat offset
   typedef struct packed {
      logic [CoordBits-1:0]  lo_x;
      logic [CoordBits-1:0]  lo_y;
      logic [CoordBits-1:0]  hi_x;
      logic [CoordBits-1:0]  hi_y;
      logic [OffsetBits-1:0] start;
   } box_entry_type;

   // Controller to datapath commands
   typedef struct packed {
      logic         load;
      logic         clear_tbl;
      res_kind_type res;
      logic         app_span;
      logic         scan_first;
      logic         scan_next;
      logic         hit_take;
      logic         mul;
      logic         app_acc;
      logic         qry_sum;
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic full;
      logic empty;
      logic hit;
      logic last;
   } dp_stat_type;

endpackage

// File: sv/rcpi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the box table.
module rcpi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/rcpi_ctrl.sv
// Controller state machine for the refined cell parent index block.
// Depends on rcpi_pkg; drives rcpi_dp through command and status structs.
module rcpi_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  rcpi_pkg::cmd_type     req_cmd,
   input  rcpi_pkg::dp_stat_type stat,
   output rcpi_pkg::ctrl_cmd_type cmd,
   output logic                  busy,
   output logic                  rsp_strobe
);
   import rcpi_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_cmd)
                  CMD_CLEAR:  state_in = ST_RESP;
                  CMD_APPEND: state_in = stat.full ? ST_RESP : ST_APP_SPAN;
                  CMD_QUERY:  state_in = stat.empty ? ST_RESP : ST_QRY_FIRST;
                  CMD_NOP:    state_in = ST_RESP;
                  default:    state_in = ST_RESP;
               endcase
            end
         end
         ST_APP_SPAN:  state_in = ST_APP_MUL;
         ST_APP_MUL:   state_in = ST_APP_ACC;
         ST_APP_ACC:   state_in = ST_RESP;
         ST_QRY_FIRST: state_in = ST_QRY_SCAN;
         ST_QRY_SCAN: begin
            priority if (stat.hit) begin
               state_in = ST_QRY_MUL;
            end else if (stat.last) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_QRY_SCAN;
            end
         end
         ST_QRY_MUL:   state_in = ST_QRY_SUM;
         ST_QRY_SUM:   state_in = ST_RESP;
         ST_RESP:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Command outputs
   always_comb begin
      cmd        = '0;
      busy       = (state_ff != ST_IDLE);
      rsp_strobe = (state_ff == ST_RESP);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               unique case (req_cmd)
                  CMD_CLEAR: begin
                     cmd.clear_tbl = 1'b1;
                     cmd.res       = RES_OK;
                  end
                  CMD_APPEND: begin
                     if (stat.full) begin
                        cmd.res = RES_FULL;
                     end
                  end
                  CMD_QUERY: begin
                     if (stat.empty) begin
                        cmd.res = RES_MISS;
                     end
                  end
                  CMD_NOP:  cmd.res = RES_OK;
                  default:  cmd.res = RES_OK;
               endcase
            end
         end
         ST_APP_SPAN:  cmd.app_span   = 1'b1;
         ST_APP_MUL:   cmd.mul        = 1'b1;
         ST_APP_ACC:   cmd.app_acc    = 1'b1;
         ST_QRY_FIRST: cmd.scan_first = 1'b1;
         ST_QRY_SCAN: begin
            priority if (stat.hit) begin
               cmd.hit_take = 1'b1;
            end else if (stat.last) begin
               cmd.res = RES_MISS;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_QRY_MUL:   cmd.mul     = 1'b1;
         ST_QRY_SUM:   cmd.qry_sum = 1'b1;
         ST_RESP:      cmd         = '0;
         default:      cmd         = '0;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/rcpi_dp.sv
// Datapath: request registers, box table, scan compare, shared multiplier.
// Depends on rcpi_pkg and rcpi_ram; commanded by rcpi_ctrl.
module rcpi_dp #(
   parameter int MAX_BOXES = rcpi_pkg::MaxBoxesDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rcpi_pkg::ctrl_cmd_type              cmd,
   input  logic [rcpi_pkg::CoordBits-1:0]      req_box_lo_x,
   input  logic [rcpi_pkg::CoordBits-1:0]      req_box_lo_y,
   input  logic [rcpi_pkg::CoordBits-1:0]      req_box_hi_x,
   input  logic [rcpi_pkg::CoordBits-1:0]      req_box_hi_y,
   input  logic [rcpi_pkg::CoordBits-1:0]      req_cell_x,
   input  logic [rcpi_pkg::CoordBits-1:0]      req_cell_y,
   output rcpi_pkg::dp_stat_type               stat,
   output logic [1:0]                          rsp_status,
   output logic [rcpi_pkg::OffsetBits-1:0]     rsp_parent_index,
   output logic [rcpi_pkg::BoxNumBits-1:0]     rsp_coarse_box
);
   import rcpi_pkg::*;

   localparam int IdxW  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CntW  = $clog2(MAX_BOXES + 1);
   localparam int SpanW = CoordBits + 1;
   localparam int ProdW = 2 * SpanW;
   localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_BOXES);

   // Latched request fields
   logic [CoordBits-1:0]  lo_x_ff, lo_y_ff, hi_x_ff, hi_y_ff;
   logic [CoordBits-1:0]  lo_x_in, lo_y_in, hi_x_in, hi_y_in;
   logic [CoordBits-2:0]  px_ff, py_ff, px_in, py_in;
   // Table bookkeeping
   logic [CntW-1:0]       loaded_ff, loaded_in;
   logic [OffsetBits-1:0] total_ff, total_in;
   logic [CntW-1:0]       cmp_idx_ff, cmp_idx_in;
   // Shared multiplier and sum
   logic [SpanW-1:0]      mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic [ProdW-1:0]      prod_ff, prod_in;
   logic [OffsetBits-1:0] base_ff, base_in;
   // Response word
   status_type            status_ff, status_in;
   logic [OffsetBits-1:0] pidx_ff, pidx_in;
   logic [IdxW-1:0]       pbox_ff, pbox_in;

   // Table access
   box_entry_type         wr_entry, rd_entry;
   logic [$bits(box_entry_type)-1:0] rd_raw;
   logic [IdxW-1:0]       rd_addr;
   logic [CntW-1:0]       nxt_idx;

   // Compare and span arithmetic
   logic [CoordBits-1:0]  px_ext, py_ext;
   logic [CoordBits-1:0]  dx, dy;
   logic [SpanW-1:0]      width_x, span_x, span_y;
   logic                  in_x, in_y;
   logic [IdxW+BoxNumBits-1:0] pbox_ext;

   assign nxt_idx = cmp_idx_ff + CntW'(1);
   assign rd_addr = cmd.scan_first ? '0 : nxt_idx[IdxW-1:0];

   assign wr_entry.lo_x  = lo_x_ff;
   assign wr_entry.lo_y  = lo_y_ff;
   assign wr_entry.hi_x  = hi_x_ff;
   assign wr_entry.hi_y  = hi_y_ff;
   assign wr_entry.start = total_ff;

   rcpi_ram #(
      .WIDTH ($bits(box_entry_type)),
      .DEPTH (MAX_BOXES)
   ) u_box_ram (
      .clock   (clock),
      .wr_en   (cmd.app_span),
      .wr_addr (loaded_ff[IdxW-1:0]),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry = box_entry_type'(rd_raw);

   // Containment test of the halved point against the entry just read
   assign px_ext  = {1'b0, px_ff};
   assign py_ext  = {1'b0, py_ff};
   assign in_x    = (px_ext >= rd_entry.lo_x) && (px_ext <= rd_entry.hi_x);
   assign in_y    = (py_ext >= rd_entry.lo_y) && (py_ext <= rd_entry.hi_y);
   assign dx      = px_ext - rd_entry.lo_x;
   assign dy      = py_ext - rd_entry.lo_y;
   assign width_x = {1'b0, rd_entry.hi_x} - {1'b0, rd_entry.lo_x} + SpanW'(1);

   // Cell counts along each axis of the box being appended; inverted gives 0
   assign span_x = (hi_x_ff < lo_x_ff) ? '0
                                       : ({1'b0, hi_x_ff} - {1'b0, lo_x_ff} + SpanW'(1));
   assign span_y = (hi_y_ff < lo_y_ff) ? '0
                                       : ({1'b0, hi_y_ff} - {1'b0, lo_y_ff} + SpanW'(1));

   assign stat.full  = (loaded_ff == MaxCnt);
   assign stat.empty = (loaded_ff == '0);
   assign stat.hit   = in_x && in_y;
   assign stat.last  = (nxt_idx == loaded_ff);

   // Next values
   always_comb begin
      lo_x_in    = lo_x_ff;
      lo_y_in    = lo_y_ff;
      hi_x_in    = hi_x_ff;
      hi_y_in    = hi_y_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      loaded_in  = loaded_ff;
      total_in   = total_ff;
      cmp_idx_in = cmp_idx_ff;
      mul_a_in   = mul_a_ff;
      mul_b_in   = mul_b_ff;
      prod_in    = prod_ff;
      base_in    = base_ff;
      status_in  = status_ff;
      pidx_in    = pidx_ff;
      pbox_in    = pbox_ff;

      // capture the request word; halve the cell for the coarse level
      if (cmd.load) begin
         lo_x_in = req_box_lo_x;
         lo_y_in = req_box_lo_y;
         hi_x_in = req_box_hi_x;
         hi_y_in = req_box_hi_y;
         px_in   = req_cell_x[CoordBits-1:1];
         py_in   = req_cell_y[CoordBits-1:1];
      end

      if (cmd.clear_tbl) begin
         loaded_in = '0;
         total_in  = '0;
      end

      // fixed responses
      unique case (cmd.res)
         RES_OK: begin
            status_in = STATUS_OK;
            pidx_in   = '0;
            pbox_in   = '0;
         end
         RES_MISS: begin
            status_in = STATUS_MISS;
            pidx_in   = '0;
            pbox_in   = '0;
         end
         RES_FULL: begin
            status_in = STATUS_FULL;
            pidx_in   = '0;
            pbox_in   = '0;
         end
         RES_NONE: begin
         end
         default: begin
         end
      endcase

      // append: cell count = span_x * span_y
      if (cmd.app_span) begin
         mul_a_in = span_x;
         mul_b_in = span_y;
      end

      if (cmd.mul) begin
         prod_in = mul_a_ff * mul_b_ff;
      end

      if (cmd.app_acc) begin
         total_in  = total_ff + prod_ff[OffsetBits-1:0];
         loaded_in = loaded_ff + CntW'(1);
         status_in = STATUS_OK;
         pidx_in   = '0;
         pbox_in   = loaded_ff[IdxW-1:0];
      end

      // scan walk
      if (cmd.scan_first) begin
         cmp_idx_in = '0;
      end
      if (cmd.scan_next) begin
         cmp_idx_in = nxt_idx;
      end

      // hit: index = start + dx + dy * width
      if (cmd.hit_take) begin
         base_in  = rd_entry.start + OffsetBits'(dx);
         mul_a_in = {1'b0, dy};
         mul_b_in = width_x;
         pbox_in  = cmp_idx_ff[IdxW-1:0];
      end

      if (cmd.qry_sum) begin
         status_in = STATUS_OK;
         pidx_in   = base_ff + prod_ff[OffsetBits-1:0];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
         total_ff  <= '0;
      end else begin
         loaded_ff <= loaded_in;
         total_ff  <= total_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      lo_x_ff    <= lo_x_in;
      lo_y_ff    <= lo_y_in;
      hi_x_ff    <= hi_x_in;
      hi_y_ff    <= hi_y_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      cmp_idx_ff <= cmp_idx_in;
      mul_a_ff   <= mul_a_in;
      mul_b_ff   <= mul_b_in;
      prod_ff    <= prod_in;
      base_ff    <= base_in;
      status_ff  <= status_in;
      pidx_ff    <= pidx_in;
      pbox_ff    <= pbox_in;
   end

   // Response word; box number shown in its low bits
   assign pbox_ext         = {{BoxNumBits{1'b0}}, pbox_ff};
   assign rsp_status       = status_ff;
   assign rsp_parent_index = pidx_ff;
   assign rsp_coarse_box   = pbox_ext[BoxNumBits-1:0];

endmodule

// File: sv/refined_cell_parent_index_top.sv
// Top level of the refined cell parent index block.
// Depends on rcpi_pkg, rcpi_ctrl, rcpi_dp (and rcpi_ram below it).
//
//   channel   handshake            word
//   request   start / busy         req_cmd, box corners, cell_x/y
//   response  rsp_strobe (1 cycle) rsp_status, rsp_parent_index, rsp_coarse_box
//
// A request word is taken when start is high and busy is low; one word at a time.
// Clear, no-op, full append and empty-table query go straight to the response;
// append steps through span, multiply and accumulate; query reads the first box,
// scans in order to a hit or the last box, then on a hit multiplies and sums, one
// box compared per cycle through the box table RAM read port. The response strobes
// in the cycle before busy falls. Synchronous active-high reset empties the table;
// the receiver cannot stall the response.
module refined_cell_parent_index_top #(
   parameter int MAX_BOXES = rcpi_pkg::MaxBoxesDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_cmd,
   input  logic [rcpi_pkg::CoordBits-1:0]      req_box_lo_x,
   input  logic [rcpi_pkg::CoordBits-1:0]      req_box_lo_y,
   input  logic [rcpi_pkg::CoordBits-1:0]      req_box_hi_x,
   input  logic [rcpi_pkg::CoordBits-1:0]      req_box_hi_y,
   input  logic [rcpi_pkg::CoordBits-1:0]      req_cell_x,
   input  logic [rcpi_pkg::CoordBits-1:0]      req_cell_y,
   output logic                                rsp_strobe,
   output logic [1:0]                          rsp_status,
   output logic [rcpi_pkg::OffsetBits-1:0]     rsp_parent_index,
   output logic [rcpi_pkg::BoxNumBits-1:0]     rsp_coarse_box
);
   import rcpi_pkg::*;

   ctrl_cmd_type ctrl_cmd;
   dp_stat_type  dp_stat;

   // Sequencer
   rcpi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_cmd    (cmd_type'(req_cmd)),
      .stat       (dp_stat),
      .cmd        (ctrl_cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // Table, compare and arithmetic
   rcpi_dp #(
      .MAX_BOXES (MAX_BOXES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (ctrl_cmd),
      .req_box_lo_x     (req_box_lo_x),
      .req_box_lo_y     (req_box_lo_y),
      .req_box_hi_x     (req_box_hi_x),
      .req_box_hi_y     (req_box_hi_y),
      .req_cell_x       (req_cell_x),
      .req_cell_y       (req_cell_y),
      .stat             (dp_stat),
      .rsp_status       (rsp_status),
      .rsp_parent_index (rsp_parent_index),
      .rsp_coarse_box   (rsp_coarse_box)
   );

endmodule

// File: tb/rcpi_parent_checker.sv
// Checker for the refined cell parent index block: watches both channels,
// predicts each response word from its own copy of the box table and compares.
// Depends on rcpi_pkg.
module rcpi_parent_checker #(
   parameter int TableDepth = rcpi_pkg::MaxBoxesDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic [1:0]                      req_cmd,
   input  logic [rcpi_pkg::CoordBits-1:0]  req_box_lo_x,
   input  logic [rcpi_pkg::CoordBits-1:0]  req_box_lo_y,
   input  logic [rcpi_pkg::CoordBits-1:0]  req_box_hi_x,
   input  logic [rcpi_pkg::CoordBits-1:0]  req_box_hi_y,
   input  logic [rcpi_pkg::CoordBits-1:0]  req_cell_x,
   input  logic [rcpi_pkg::CoordBits-1:0]  req_cell_y,
   input  logic                            rsp_strobe,
   input  logic [1:0]                      rsp_status,
   input  logic [rcpi_pkg::OffsetBits-1:0] rsp_parent_index,
   input  logic [rcpi_pkg::BoxNumBits-1:0] rsp_coarse_box,
   output int                              fail_count,
   output int                              pending,
   output int                              results_checked,
   output int                              hit_count,
   output int                              full_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import rcpi_pkg::*;

   // One response word as the block should give it
   typedef struct packed {
      status_type            status;
      logic [OffsetBits-1:0] index;
      logic [BoxNumBits-1:0] box;
   } parent_word_type;

   // Own copy of the coarse box table
   logic [CoordBits-1:0]  tbl_lo_x  [TableDepth];
   logic [CoordBits-1:0]  tbl_lo_y  [TableDepth];
   logic [CoordBits-1:0]  tbl_hi_x  [TableDepth];
   logic [CoordBits-1:0]  tbl_hi_y  [TableDepth];
   logic [OffsetBits-1:0] tbl_start [TableDepth];
   int                    tbl_count;
   logic [OffsetBits-1:0] cell_total;

   parent_word_type expected_parents [$];
   int              mismatches;
   int              n_checked;
   int              n_hits;
   int              n_full;

   initial begin
      tbl_count  = 0;
      cell_total = '0;
      mismatches = 0;
      n_checked  = 0;
      n_hits     = 0;
      n_full     = 0;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40) begin
         $display("%0t ns  mismatch: %s", $time, what);
      end
   endtask

   // Apply one request word to the table copy and work out its response word
   function automatic parent_word_type parent_of_word(
      input cmd_type              c,
      input logic [CoordBits-1:0] lx,
      input logic [CoordBits-1:0] ly,
      input logic [CoordBits-1:0] hx,
      input logic [CoordBits-1:0] hy,
      input logic [CoordBits-1:0] cx,
      input logic [CoordBits-1:0] cy
   );
      parent_word_type      r;
      logic [16:0]          span_x;
      logic [16:0]          span_y;
      logic [63:0]          cells;
      logic [63:0]          flat;
      logic [CoordBits-1:0] px;
      logic [CoordBits-1:0] py;
      bit                   found;
      r.status = STATUS_OK;
      r.index  = '0;
      r.box    = '0;
      case (c)
         CMD_CLEAR: begin
            tbl_count  = 0;
            cell_total = '0;
         end
         CMD_APPEND: begin
            if (tbl_count >= TableDepth) begin
               r.status = STATUS_FULL;
            end else begin
               // inverted spans count no cells
               span_x = (hx < lx) ? 17'd0 : {1'b0, hx} - {1'b0, lx} + 17'd1;
               span_y = (hy < ly) ? 17'd0 : {1'b0, hy} - {1'b0, ly} + 17'd1;
               cells  = 64'(span_x) * 64'(span_y);
               tbl_lo_x[tbl_count]  = lx;
               tbl_lo_y[tbl_count]  = ly;
               tbl_hi_x[tbl_count]  = hx;
               tbl_hi_y[tbl_count]  = hy;
               tbl_start[tbl_count] = cell_total;
               cell_total = cell_total + cells[OffsetBits-1:0];
               r.box = BoxNumBits'(tbl_count);
               tbl_count++;
            end
         end
         CMD_QUERY: begin
            // refinement ratio 2: halve the fine cell, first box in order wins
            px    = cx >> 1;
            py    = cy >> 1;
            found = 1'b0;
            for (int i = 0; i < tbl_count && !found; i++) begin
               if (px >= tbl_lo_x[i] && px <= tbl_hi_x[i] &&
                   py >= tbl_lo_y[i] && py <= tbl_hi_y[i]) begin
                  flat = 64'(tbl_start[i]) + 64'(px - tbl_lo_x[i]) +
                         64'(py - tbl_lo_y[i]) *
                         (64'(tbl_hi_x[i]) - 64'(tbl_lo_x[i]) + 64'd1);
                  r.index = flat[OffsetBits-1:0];
                  r.box   = BoxNumBits'(i);
                  found   = 1'b1;
               end
            end
            if (!found) begin
               r.status = STATUS_MISS;
            end
         end
         default: ;  // no-op leaves the table alone
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      parent_word_type want;
      if (reset) begin
         tbl_count  = 0;
         cell_total = '0;
         expected_parents.delete();
      end else begin
         // response words first: a word at this edge belongs to an earlier request
         if (rsp_strobe) begin
            if (expected_parents.size() == 0) begin
               report_mismatch($sformatf("response word with none expected: %0d %h %0d",
                                         rsp_status, rsp_parent_index, rsp_coarse_box));
            end else begin
               want = expected_parents.pop_front();
               n_checked++;
               if (rsp_status !== want.status) begin
                  report_mismatch($sformatf("word %0d status got %0d want %0d",
                                            n_checked, rsp_status, want.status));
               end
               if (rsp_parent_index !== want.index) begin
                  report_mismatch($sformatf("word %0d parent_index got %h want %h",
                                            n_checked, rsp_parent_index, want.index));
               end
               if (rsp_coarse_box !== want.box) begin
                  report_mismatch($sformatf("word %0d coarse_box got %0d want %0d",
                                            n_checked, rsp_coarse_box, want.box));
               end
            end
         end
         if (start && !busy) begin
            want = parent_of_word(cmd_type'(req_cmd), req_box_lo_x, req_box_lo_y,
                                  req_box_hi_x, req_box_hi_y, req_cell_x, req_cell_y);
            if (want.status == STATUS_FULL) begin
               n_full++;
            end
            if (req_cmd == CMD_QUERY && want.status == STATUS_OK) begin
               n_hits++;
            end
            expected_parents.push_back(want);
         end
      end
      fail_count      <= mismatches;
      pending         <= expected_parents.size();
      results_checked <= n_checked;
      hit_count       <= n_hits;
      full_count      <= n_full;
   end

endmodule

// File: tb/refined_cell_parent_index_top_tb.sv
// Testbench top for the refined cell parent index block: drives request words,
// runs the watchdog and gives the verdict.
// Depends on rcpi_pkg, refined_cell_parent_index_top and rcpi_parent_checker.
module refined_cell_parent_index_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rcpi_pkg::*;

   localparam int TableDepth  = MaxBoxesDefault;
   localparam int ItemTarget  = 2000;
   localparam int QuietItems  = 200;
   localparam int DrainCycles = 100;
   localparam int StallLimit  = 1000;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [1:0]            req_cmd;
   logic [CoordBits-1:0]  req_box_lo_x;
   logic [CoordBits-1:0]  req_box_lo_y;
   logic [CoordBits-1:0]  req_box_hi_x;
   logic [CoordBits-1:0]  req_box_hi_y;
   logic [CoordBits-1:0]  req_cell_x;
   logic [CoordBits-1:0]  req_cell_y;
   logic                  rsp_strobe;
   logic [1:0]            rsp_status;
   logic [OffsetBits-1:0] rsp_parent_index;
   logic [BoxNumBits-1:0] rsp_coarse_box;

   int fail_count;
   int pending;
   int results_checked;
   int hit_count;
   int full_count;

   // Corners of the boxes loaded so far, used only to aim queries
   logic [CoordBits-1:0] aim_lo_x [TableDepth];
   logic [CoordBits-1:0] aim_lo_y [TableDepth];
   logic [CoordBits-1:0] aim_hi_x [TableDepth];
   logic [CoordBits-1:0] aim_hi_y [TableDepth];
   int                   aim_count;

   int words_sent;
   int n_appends;
   int n_queries;
   int stall_cycles;
   bit quiet;
   bit gappy;

   refined_cell_parent_index_top #(.MAX_BOXES(TableDepth)) uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_box_lo_x     (req_box_lo_x),
      .req_box_lo_y     (req_box_lo_y),
      .req_box_hi_x     (req_box_hi_x),
      .req_box_hi_y     (req_box_hi_y),
      .req_cell_x       (req_cell_x),
      .req_cell_y       (req_cell_y),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_parent_index (rsp_parent_index),
      .rsp_coarse_box   (rsp_coarse_box)
   );

   rcpi_parent_checker #(.TableDepth(TableDepth)) parent_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_box_lo_x     (req_box_lo_x),
      .req_box_lo_y     (req_box_lo_y),
      .req_box_hi_x     (req_box_hi_x),
      .req_box_hi_y     (req_box_hi_y),
      .req_cell_x       (req_cell_x),
      .req_cell_y       (req_cell_y),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_parent_index (rsp_parent_index),
      .rsp_coarse_box   (rsp_coarse_box),
      .fail_count       (fail_count),
      .pending          (pending),
      .results_checked  (results_checked),
      .hit_count        (hit_count),
      .full_count       (full_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: cycles in which no word moves on either channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("watchdog: no word moved for %0d cycles", StallLimit);
         $display("== FAIL ==");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic logic [CoordBits-1:0] rnd_coord();
      return CoordBits'($urandom);
   endfunction

   // Corner, far corner or anywhere between
   function automatic logic [CoordBits-1:0] pick_within(
      input logic [CoordBits-1:0] lo,
      input logic [CoordBits-1:0] hi
   );
      case ($urandom_range(0, 3))
         0:       return lo;
         1:       return hi;
         default: return lo + CoordBits'($urandom_range(0, hi - lo));
      endcase
   endfunction

   // Drive one request word, hold it until taken, then maybe idle a burst
   task automatic send_word(
      input cmd_type              c,
      input logic [CoordBits-1:0] lx,
      input logic [CoordBits-1:0] ly,
      input logic [CoordBits-1:0] hx,
      input logic [CoordBits-1:0] hy,
      input logic [CoordBits-1:0] cx,
      input logic [CoordBits-1:0] cy
   );
      req_cmd      <= c;
      req_box_lo_x <= lx;
      req_box_lo_y <= ly;
      req_box_hi_x <= hx;
      req_box_hi_y <= hy;
      req_cell_x   <= cx;
      req_cell_y   <= cy;
      start        <= 1'b1;
      do @(posedge clock); while (busy);
      words_sent++;
      case (c)
         CMD_CLEAR: aim_count = 0;
         CMD_APPEND: begin
            n_appends++;
            if (aim_count < TableDepth) begin
               aim_lo_x[aim_count] = lx;
               aim_lo_y[aim_count] = ly;
               aim_hi_x[aim_count] = hx;
               aim_hi_y[aim_count] = hy;
               aim_count++;
            end
         end
         CMD_QUERY: n_queries++;
         default: ;
      endcase
      if (gappy && !quiet && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // Mostly small, reachable boxes; now and then inverted, huge or out of reach
   task automatic add_random_box();
      logic [CoordBits-1:0] lx, ly, hx, hy;
      int                   kind;
      kind = $urandom_range(0, 15);
      if (kind == 0) begin
         lx = rnd_coord();
         ly = rnd_coord();
         hx = rnd_coord();
         hy = rnd_coord();
      end else if (kind == 1) begin
         // huge box: cell count near 2^32, running total wraps
         lx = CoordBits'($urandom_range(0, 255));
         ly = CoordBits'($urandom_range(0, 255));
         hx = 16'hFFFF - CoordBits'($urandom_range(0, 255));
         hy = 16'hFFFF - CoordBits'($urandom_range(0, 255));
      end else if (kind == 2) begin
         // above any halved cell, so never a parent
         lx = CoordBits'($urandom_range(16'h8000, 16'hFFF0));
         ly = CoordBits'($urandom_range(16'h8000, 16'hFFF0));
         hx = lx + CoordBits'($urandom_range(0, 15));
         hy = ly + CoordBits'($urandom_range(0, 15));
      end else begin
         lx = CoordBits'($urandom_range(0, 32700));
         ly = CoordBits'($urandom_range(0, 32700));
         hx = lx + CoordBits'($urandom_range(0, (kind < 5) ? 2047 : 15));
         hy = ly + CoordBits'($urandom_range(0, (kind < 5) ? 2047 : 15));
      end
      send_word(CMD_APPEND, lx, ly, hx, hy, rnd_coord(), rnd_coord());
   endtask

   // Query a fine cell whose halved point lies in a loaded box where possible
   task automatic query_loaded_box();
      int                   j;
      logic [CoordBits-1:0] px, py;
      j = (aim_count == 0) ? 0 : $urandom_range(0, aim_count - 1);
      if (aim_count == 0 || aim_hi_x[j] < aim_lo_x[j] || aim_hi_y[j] < aim_lo_y[j] ||
          aim_lo_x[j] > 16'h7FFF || aim_lo_y[j] > 16'h7FFF) begin
         send_word(CMD_QUERY, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                   rnd_coord(), rnd_coord());
      end else begin
         px = pick_within(aim_lo_x[j], (aim_hi_x[j] > 16'h7FFF) ? 16'h7FFF : aim_hi_x[j]);
         py = pick_within(aim_lo_y[j], (aim_hi_y[j] > 16'h7FFF) ? 16'h7FFF : aim_hi_y[j]);
         send_word(CMD_QUERY, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                   {px[CoordBits-2:0], 1'($urandom)}, {py[CoordBits-2:0], 1'($urandom)});
      end
   endtask

   initial begin
      int  n_boxes;
      int  pick;
      bit  fill;
      reset        <= 1'b1;
      start        <= 1'b0;
      req_cmd      <= CMD_NOP;
      req_box_lo_x <= '0;
      req_box_lo_y <= '0;
      req_box_hi_x <= '0;
      req_box_hi_y <= '0;
      req_cell_x   <= '0;
      req_cell_y   <= '0;
      stall_cycles = 0;
      aim_count    = 0;
      words_sent   = 0;
      n_appends    = 0;
      n_queries    = 0;
      quiet        = 1'b0;
      gappy        = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, no-op, tiny / inverted / huge / unreachable boxes,
      // corners of a box, first box wins on overlap, wrap of the offsets
      send_word(CMD_CLEAR,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_word(CMD_QUERY,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
      send_word(CMD_NOP,    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(CMD_APPEND, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
      send_word(CMD_APPEND, 16'd10,   16'd20,   16'd19,   16'd29,   16'h0000, 16'h0000);
      send_word(CMD_APPEND, 16'd200,  16'd200,  16'd100,  16'd100,  16'h0000, 16'h0000);
      send_word(CMD_APPEND, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
      send_word(CMD_APPEND, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
      send_word(CMD_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0,    16'd0);
      send_word(CMD_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd1,    16'd1);
      send_word(CMD_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd21,   16'd41);
      send_word(CMD_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd39,   16'd59);
      send_word(CMD_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd300,  16'd300);
      send_word(CMD_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
      send_word(CMD_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd40,   16'd20);
      send_word(CMD_CLEAR,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(CMD_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd21,   16'd41);
      send_word(CMD_APPEND, 16'h7FFF, 16'h0000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0000);
      send_word(CMD_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFE, 16'h1234);
      send_word(CMD_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFD, 16'h1234);
      send_word(CMD_NOP,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

      // Random: build a table, then mostly aimed queries with some noise
      while (words_sent < ItemTarget) begin
         quiet = (words_sent >= ItemTarget - QuietItems);
         gappy = ($urandom_range(0, 2) != 0);
         fill  = ($urandom_range(0, 7) == 0);
         n_boxes = fill ? TableDepth : $urandom_range(1, 12);
         if (fill || $urandom_range(0, 3) != 0) begin
            send_word(CMD_CLEAR, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                      rnd_coord(), rnd_coord());
         end
         repeat (n_boxes) add_random_box();
         if (fill) begin
            repeat ($urandom_range(1, 3)) add_random_box();
         end
         repeat ($urandom_range(4, 30)) begin
            pick = $urandom_range(0, 15);
            if (pick < 11) begin
               query_loaded_box();
            end else if (pick < 14) begin
               send_word(CMD_QUERY, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                         rnd_coord(), rnd_coord());
            end else if (pick == 14) begin
               send_word(CMD_NOP, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                         rnd_coord(), rnd_coord());
            end else begin
               add_random_box();
            end
         end
      end

      // Drain: all responses in, then a margin for stray words
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d request words: %0d appends (%0d refused, table full), %0d queries.",
               words_sent, n_appends, full_count, n_queries);
      $display("Checked %0d response words; %0d queries found a parent box.",
               results_checked, hit_count);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/rcpi_pkg.sv
sv/rcpi_ram.sv
sv/rcpi_ctrl.sv
sv/rcpi_dp.sv
sv/refined_cell_parent_index_top.sv
tb/rcpi_parent_checker.sv
tb/refined_cell_parent_index_top_tb.sv
